@@ design/pooled_linked_list_manager_defines.svh @@
// Assertion macros shared by the pooled linked list manager.
`ifndef POOLED_LINKED_LIST_MANAGER_DEFINES_SVH
`define POOLED_LINKED_LIST_MANAGER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define PLLM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pllm: same-cycle property failed");

// Next-cycle implication, switched off while reset is high.
`define PLLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pllm: next-cycle property failed");

`endif

@@ design/pllm_pkg.sv @@
// Types, constants and codes of the pooled linked list manager.
package pllm_pkg;

   // Pool geometry. A link holds one more code than there are slots: the null link.
   localparam int POOL_SLOTS = 64;
   localparam int IDX_W      = $clog2(POOL_SLOTS);
   localparam int LINK_W     = $clog2(POOL_SLOTS + 1);
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SLOTS);

   // Field widths of the request and response.
   localparam int TYPE_W      = 2;
   localparam int POS_W       = 6;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 3;
   localparam int REQ_TDATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((DATA_W + STATUS_W + 7) / 8) * 8;

   // Request kinds.
   typedef enum logic [TYPE_W-1:0] {
      REQ_APPEND = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_READ   = 2'd2,
      REQ_WRITE  = 2'd3
   } req_kind_type;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_HEAD_FILLED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LAST_REMOVED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HEAD_REFUSED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_POOL_FULL    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BEYOND_END   = 3'd5;

   // One slot of the pool as held in memory.
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [LINK_W-1:0] link;
   } slot_type;

   // Write port of the slot store.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      slot_type         slot;
   } slot_wr_type;

   // Read port of the slot store.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } slot_rd_type;

endpackage

@@ design/pllm_store.sv @@
// Slot store: data word and next link of every pool slot, with per-slot written flags.
module pllm_store import pllm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  slot_rd_type rd,
   input  slot_wr_type wr,
   output slot_type    rd_slot
);

   slot_type               slot_mem [POOL_SLOTS];
   slot_type               rd_data_ff;
   logic [POOL_SLOTS-1:0]  written_ff;
   logic [POOL_SLOTS-1:0]  written_in;
   logic                   rd_written_ff;
   logic                   rd_written_in;

   // The memory itself: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         slot_mem[wr.addr] <= wr.slot;
      end
      if (rd.en) begin
         rd_data_ff <= slot_mem[rd.addr];
      end
   end

   // A slot counts as written once any write has reached it since reset.
   always_comb begin
      written_in = written_ff;
      if (wr.en) begin
         written_in[wr.addr] = 1'b1;
      end
      rd_written_in = rd.en ? written_ff[rd.addr] : rd_written_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         written_ff    <= written_in;
         rd_written_ff <= rd_written_in;
      end
   end

   // A slot never written reads as its reset contents: zero data, null link.
   assign rd_slot = rd_written_ff ? rd_data_ff : slot_type'{value: '0, link: NULL_LINK};

endmodule

@@ design/pooled_linked_list_manager.sv @@
// Top level of the pooled linked list manager: request sequencer and response register.
//
// One singly linked list lives in a pool of POOL_SLOTS slots held in a single
// memory with a registered read; slot 0 is always the head. A request is taken
// only while the sequencer is idle, but a finished response may still be
// waiting on rsp_tready when the next request is taken. Every step of a walk
// is one read of the slot memory. A read, write or remove at position p walks
// from the head towards p and stops early at the tail, and a remove at
// position zero is refused without a walk. An append to an empty list writes
// the head directly; any other append first scans the used flags one slot per
// cycle from slot 1 up to the first free slot, then walks the whole list to
// its tail, and a full pool is reported once the scan reaches the last slot.
// A finished result also waits until the previous response has been taken on
// rsp_tready. No clearing pass is needed after reset.
`include "pooled_linked_list_manager_defines.svh"

module pooled_linked_list_manager import pllm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // Requests
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [5:0] position, [37:6] value, rest zero
   input  logic [TYPE_W-1:0]      req_tuser,   // [1:0] req_type
   // Responses
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [31:0] read_data, [34:32] status, rest zero
);

   localparam int RSP_PAD_W = RSP_TDATA_W - DATA_W - STATUS_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_APPEND = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_WALK   = 5'b01000,
      ST_RESULT = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   req_kind_type          op_ff, op_in;
   logic [POS_W-1:0]      left_ff, left_in;
   logic [DATA_W-1:0]     value_ff, value_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic [IDX_W-1:0]      prev_ff, prev_in;
   logic [DATA_W-1:0]     prev_val_ff, prev_val_in;
   logic [LINK_W-1:0]     steps_ff, steps_in;
   logic [IDX_W-1:0]      free_ff, free_in;
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic [DATA_W-1:0]     res_data_ff, res_data_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [POOL_SLOTS-1:0] used_ff, used_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   slot_rd_type           rd;
   slot_wr_type           wr;
   slot_type              rd_slot;
   logic                  rd_en;
   logic                  req_accept;
   logic [POS_W-1:0]      req_pos;
   logic [DATA_W-1:0]     req_value;
   logic                  link_ok;
   logic                  step_ok;

   pllm_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd      (rd),
      .wr      (wr),
      .rd_slot (rd_slot)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_pos    = req_tdata[POS_W-1:0];
   assign req_value  = req_tdata[POS_W+DATA_W-1:POS_W];
   assign rd_en      = rd.en;

   // A walk goes on while the slot just read has a real successor and the
   // target (a position, or the tail for an append) is not yet reached.
   assign link_ok = (rd_slot.link < LINK_W'(POOL_SLOTS));
   assign step_ok = ((op_ff == REQ_APPEND) || (left_ff != '0))
                    && (steps_ff < LINK_W'(POOL_SLOTS)) && link_ok;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      left_in       = left_ff;
      value_in      = value_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_val_in   = prev_val_ff;
      steps_in      = steps_ff;
      free_in       = free_ff;
      scan_in       = scan_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      used_in       = used_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rd            = '{en: 1'b0, addr: '0};
      wr            = '{en: 1'b0, addr: '0, slot: '{value: '0, link: NULL_LINK}};

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in         = req_kind_type'(req_tuser);
               left_in       = req_pos;
               value_in      = req_value;
               cur_in        = '0;
               prev_in       = '0;
               prev_val_in   = '0;
               steps_in      = '0;
               res_data_in   = '0;
               res_status_in = ST_OK;
               if (req_kind_type'(req_tuser) == REQ_APPEND) begin
                  state_in = ST_APPEND;
               end else if ((req_kind_type'(req_tuser) == REQ_REMOVE) && (req_pos == '0)) begin
                  res_status_in = ST_HEAD_REFUSED;
                  state_in      = ST_RESULT;
               end else begin
                  rd       = '{en: 1'b1, addr: '0};
                  state_in = ST_WALK;
               end
            end
         end

         // An empty list takes the value straight into the head; else the scan starts.
         ST_APPEND: begin
            if (!used_ff[0]) begin
               wr            = '{en: 1'b1, addr: '0, slot: '{value: value_ff, link: NULL_LINK}};
               used_in[0]    = 1'b1;
               res_status_in = ST_HEAD_FILLED;
               state_in      = ST_RESULT;
            end else begin
               scan_in  = IDX_W'(1);
               state_in = ST_SCAN;
            end
         end

         // Look for the lowest free slot, one flag per cycle; on a hit the new slot
         // is written at once and the walk starts; a miss at the last slot means pool full.
         ST_SCAN: begin
            if (!used_ff[scan_ff]) begin
               wr               = '{en: 1'b1, addr: scan_ff,
                                    slot: '{value: value_ff, link: NULL_LINK}};
               used_in[scan_ff] = 1'b1;
               free_in          = scan_ff;
               rd               = '{en: 1'b1, addr: '0};
               state_in         = ST_WALK;
            end else if (scan_ff == IDX_W'(POOL_SLOTS - 1)) begin
               res_status_in = ST_POOL_FULL;
               state_in      = ST_RESULT;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end

         // The slot at cur_ff is on the read port this cycle.
         ST_WALK: begin
            if (step_ok) begin
               prev_in     = cur_ff;
               prev_val_in = rd_slot.value;
               cur_in      = rd_slot.link[IDX_W-1:0];
               steps_in    = steps_ff + LINK_W'(1);
               if (op_ff != REQ_APPEND) begin
                  left_in = left_ff - POS_W'(1);
               end
               rd = '{en: 1'b1, addr: rd_slot.link[IDX_W-1:0]};
            end else begin
               state_in = ST_RESULT;
               case (op_ff)
                  REQ_READ: begin
                     res_data_in = rd_slot.value;
                  end
                  REQ_WRITE: begin
                     wr = '{en: 1'b1, addr: cur_ff,
                            slot: '{value: value_ff, link: rd_slot.link}};
                  end
                  REQ_APPEND: begin
                     // Link the freshly filled slot after the tail.
                     wr = '{en: 1'b1, addr: cur_ff,
                            slot: '{value: rd_slot.value, link: LINK_W'(free_ff)}};
                  end
                  REQ_REMOVE: begin
                     if ((left_ff != '0) || (cur_ff == '0)) begin
                        res_status_in = ST_BEYOND_END;
                     end else begin
                        used_in[cur_ff] = 1'b0;
                        wr = '{en: 1'b1, addr: prev_ff,
                               slot: '{value: prev_val_ff,
                                       link: link_ok ? rd_slot.link : NULL_LINK}};
                        res_status_in = link_ok ? ST_OK : ST_LAST_REMOVED;
                     end
                  end
                  default: begin
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end

         // Hand the result to the response register once it is free.
         ST_RESULT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Working registers and response payload.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      left_ff       <= left_in;
      value_ff      <= value_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_val_ff   <= prev_val_in;
      steps_ff      <= steps_in;
      free_ff       <= free_in;
      scan_ff       <= scan_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_status_ff, rsp_data_ff};

   // Checks on the sequencer.
   `PLLM_ASSERT_NEXT(a_head_stays_used, clock, reset, used_ff[0], used_ff[0])
   `PLLM_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != ST_IDLE)
   `PLLM_ASSERT_IMPLIES(a_walk_has_read, clock, reset, state_ff == ST_WALK, $past(rd_en))
   `PLLM_ASSERT_IMPLIES(a_data_only_for_read, clock, reset, (state_ff == ST_RESULT) && (op_ff != REQ_READ), res_data_ff == '0)

endmodule

@@ tb/pooled_linked_list_manager_tb.sv @@
// Self-checking testbench for the pooled linked list manager: directed and random requests.
`timescale 1ns / 100ps

module pooled_linked_list_manager_tb import pllm_pkg::*; ();

   // Run limits: the drain allows the slowest append, and the timeout is several times the
   // slowest correct run (about 1100 requests, each with the longest gaps and the longest walk).
   localparam int DRAIN_CYCLES     = 2 * POOL_SLOTS + 16;
   localparam int CYCLE_LIMIT      = 1_500_000;
   localparam int RANDOM_REQUESTS  = 1000;

   // One expected response.
   typedef struct {
      logic [DATA_W-1:0]   read_data;
      logic [STATUS_W-1:0] status;
   } list_reply_type;

   // Bias of a stretch of random traffic.
   typedef enum int {
      TRAFFIC_GROW,
      TRAFFIC_SHRINK,
      TRAFFIC_MIXED
   } traffic_mix_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [TYPE_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow copy of the pool, updated as each request is accepted.
   logic [DATA_W-1:0] pool_value [POOL_SLOTS];
   logic [LINK_W-1:0] pool_link  [POOL_SLOTS];
   bit                pool_used  [POOL_SLOTS];

   list_reply_type replies_due[$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             random_sent = 0;
   int             rsp_hold    = 0;
   bit             steady_flow = 1'b0;

   pooled_linked_list_manager dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [5:0] position, [37:6] value, rest zero
      .req_tuser  (req_tuser),    // [1:0] req_type
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [31:0] read_data, [34:32] status, rest zero
   );

   always #1 clock = ~clock;

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      if (steady_flow) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // A slot has a successor when its link names a slot.
   function automatic bit link_onward(int idx);
      return idx < POOL_SLOTS && pool_link[idx] < POOL_SLOTS;
   endfunction

   // Follow links from the head towards a position, stopping at the tail.
   function automatic int walk_to(input int pos, output int prev, output bit exact);
      int cur;
      int left;
      int steps;
      cur   = 0;
      prev  = 0;
      left  = pos;
      steps = 0;
      while (left > 0 && steps < POOL_SLOTS && link_onward(cur)) begin
         prev = cur;
         cur  = int'(pool_link[cur]);
         left--;
         steps++;
      end
      exact = (left == 0);
      return cur;
   endfunction

   function automatic int tail_slot();
      int cur;
      int steps;
      cur   = 0;
      steps = 0;
      while (steps < POOL_SLOTS && link_onward(cur)) begin
         cur = int'(pool_link[cur]);
         steps++;
      end
      return cur;
   endfunction

   // Number of elements on the list, used only to aim the stimulus.
   function automatic int list_length();
      int count;
      int cur;
      if (!pool_used[0]) begin
         return 0;
      end
      count = 1;
      cur   = 0;
      while (count < POOL_SLOTS && link_onward(cur)) begin
         cur = int'(pool_link[cur]);
         count++;
      end
      return count;
   endfunction

   // Apply one request to the shadow pool and return the response it must give.
   function automatic list_reply_type predict_reply(req_kind_type kind, logic [POS_W-1:0] pos,
                                                    logic [DATA_W-1:0] val);
      list_reply_type reply;
      int             cur;
      int             prev;
      int             free_slot;
      int             tail;
      bit             exact;
      reply.read_data = '0;
      reply.status    = ST_OK;
      case (kind)
         REQ_APPEND: begin
            if (!pool_used[0]) begin
               pool_used[0]  = 1'b1;
               pool_link[0]  = NULL_LINK;
               pool_value[0] = val;
               reply.status  = ST_HEAD_FILLED;
            end else begin
               free_slot = POOL_SLOTS;
               for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
                  if (!pool_used[i]) free_slot = i;
               end
               if (free_slot == POOL_SLOTS) begin
                  reply.status = ST_POOL_FULL;
               end else begin
                  tail                  = tail_slot();
                  pool_value[free_slot] = val;
                  pool_link[free_slot]  = NULL_LINK;
                  pool_used[free_slot]  = 1'b1;
                  pool_link[tail]       = LINK_W'(free_slot);
               end
            end
         end
         REQ_REMOVE: begin
            if (pos == 0) begin
               reply.status = ST_HEAD_REFUSED;
            end else begin
               cur = walk_to(int'(pos), prev, exact);
               if (!exact || cur == 0) begin
                  reply.status = ST_BEYOND_END;
               end else begin
                  pool_used[cur] = 1'b0;
                  if (!link_onward(cur)) begin
                     pool_link[prev] = NULL_LINK;
                     reply.status    = ST_LAST_REMOVED;
                  end else begin
                     pool_link[prev] = pool_link[cur];
                  end
               end
            end
         end
         REQ_READ: begin
            cur             = walk_to(int'(pos), prev, exact);
            reply.read_data = pool_value[cur];
         end
         default: begin
            cur             = walk_to(int'(pos), prev, exact);
            pool_value[cur] = val;
         end
      endcase
      return reply;
   endfunction

   // Present one request and wait for it to be taken. Valid is left high on acceptance so
   // that a back-to-back request only ever needs one assignment in that time step.
   task automatic send_request(input req_kind_type kind, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({val, pos});
      req_tuser  <= kind;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      replies_due.push_back(predict_reply(kind, pos, val));
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   // Reads and writes on a list that has never been filled act on the head slot; removes are refused.
   task automatic test_empty_list();
      send_request(REQ_READ,   6'd0,  32'd0);
      send_request(REQ_READ,   6'd63, 32'd0);
      send_request(REQ_WRITE,  6'd5,  32'h7FFF_FFFF);
      send_request(REQ_READ,   6'd0,  32'd0);
      send_request(REQ_REMOVE, 6'd0,  32'd0);
      send_request(REQ_REMOVE, 6'd1,  32'hFFFF_FFFF);
      send_request(REQ_REMOVE, 6'd63, 32'd0);
   endtask

   // Build a short list with extreme values, then read and write it, past the end as well.
   task automatic test_append_and_access();
      send_request(REQ_APPEND, 6'd0,  32'h8000_0000);
      send_request(REQ_APPEND, 6'd63, 32'hFFFF_FFFF);
      send_request(REQ_APPEND, 6'd0,  32'h0000_0000);
      send_request(REQ_APPEND, 6'd0,  32'h7FFF_FFFF);
      send_request(REQ_APPEND, 6'd0,  32'h1234_5678);
      for (int p = 0; p < 5; p++) begin
         send_request(REQ_READ, POS_W'(p), 32'd0);
      end
      send_request(REQ_READ,  6'd63, 32'd0);
      send_request(REQ_WRITE, 6'd63, 32'hA5A5_5A5A);
      send_request(REQ_WRITE, 6'd2,  32'h8000_0001);
      send_request(REQ_READ,  6'd2,  32'd0);
      send_request(REQ_READ,  6'd63, 32'd0);
   endtask

   // Refused removes, removing the tail, removing from the middle, then reusing the hole.
   task automatic test_remove_cases();
      send_request(REQ_REMOVE, 6'd0, 32'd0);
      send_request(REQ_REMOVE, 6'd9, 32'd0);
      send_request(REQ_REMOVE, 6'd4, 32'd0);
      send_request(REQ_REMOVE, 6'd1, 32'd0);
      send_request(REQ_REMOVE, 6'd3, 32'd0);
      send_request(REQ_APPEND, 6'd0, 32'hDEAD_BEEF);
      send_request(REQ_READ,   6'd3, 32'd0);
   endtask

   // Fill every slot, knock on the full pool, then punch holes and refill them.
   task automatic test_pool_full();
      wait_drained();
      while (list_length() < POOL_SLOTS) begin
         send_request(REQ_APPEND, POS_W'($urandom), $urandom);
      end
      repeat (3) send_request(REQ_APPEND, POS_W'($urandom), $urandom);
      send_request(REQ_READ,   6'd63, 32'd0);
      send_request(REQ_WRITE,  6'd63, $urandom);
      send_request(REQ_READ,   6'd62, 32'd0);
      send_request(REQ_REMOVE, 6'd63, 32'd0);
      send_request(REQ_APPEND, 6'd0,  $urandom);
      repeat (4) send_request(REQ_REMOVE, POS_W'($urandom_range(1, 60)), 32'd0);
      repeat (6) send_request(REQ_APPEND, 6'd0, $urandom);
      send_request(REQ_READ, 6'd63, 32'd0);
   endtask

   // Position aimed mostly inside the list, sometimes past its end, sometimes anywhere.
   function automatic logic [POS_W-1:0] pick_position(int length);
      int roll;
      int last;
      roll = $urandom_range(0, 99);
      last = (length > 0) ? length - 1 : 0;
      if (roll < 75) return POS_W'($urandom_range(0, last));
      if (roll < 90) return POS_W'($urandom_range((length < 63) ? length : 63, 63));
      return POS_W'($urandom);
   endfunction

   function automatic req_kind_type pick_kind(traffic_mix_type mix);
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         TRAFFIC_GROW: begin
            if (roll < 60) return REQ_APPEND;
            if (roll < 75) return REQ_READ;
            if (roll < 90) return REQ_WRITE;
            return REQ_REMOVE;
         end
         TRAFFIC_SHRINK: begin
            if (roll < 60) return REQ_REMOVE;
            if (roll < 70) return REQ_APPEND;
            if (roll < 85) return REQ_READ;
            return REQ_WRITE;
         end
         default: return req_kind_type'(roll % 4);
      endcase
   endfunction

   // Stretches of biased traffic so the list grows to full, shrinks to the head and churns.
   task automatic test_random_traffic();
      traffic_mix_type mix;
      int              stretch;
      req_kind_type    kind;
      while (random_sent < RANDOM_REQUESTS) begin
         mix         = traffic_mix_type'($urandom_range(0, 2));
         steady_flow = ($urandom_range(0, 3) == 0);
         stretch     = $urandom_range(20, 80);
         for (int n = 0; n < stretch; n++) begin
            kind = pick_kind(mix);
            send_request(kind, pick_position(list_length()), $urandom);
            random_sent++;
         end
         if ($urandom_range(0, 4) == 0) begin
            wait_drained();
         end
      end
      steady_flow = 1'b0;
   endtask

   // Response side: random stalls on tready.
   always @(posedge clock) begin : rsp_stall
      int gap;
      if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= gap - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each accepted response with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      list_reply_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (replies_due.size() == 0) begin
            $error("response with no request outstanding: read_data %h status %0d",
                   rsp_tdata[31:0], rsp_tdata[34:32]);
            error_count++;
         end else begin
            due = replies_due.pop_front();
            if (rsp_tdata[31:0] !== due.read_data) begin
               $error("read_data: expected %h, actual %h", due.read_data, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[34:32] !== due.status) begin
               $error("status: expected %0d, actual %0d", due.status, rsp_tdata[34:32]);
               error_count++;
            end
            if (rsp_tdata[RSP_TDATA_W-1:35] !== '0) begin
               $error("padding: expected %h, actual %h", 5'h0, rsp_tdata[RSP_TDATA_W-1:35]);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("pooled_linked_list_manager_tb: FAIL");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
         pool_value[i] = '0;
         pool_link[i]  = NULL_LINK;
         pool_used[i]  = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_append_and_access();
      test_remove_cases();
      test_pool_full();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("pooled_linked_list_manager_tb: PASS");
      end else begin
         $display("pooled_linked_list_manager_tb: FAIL");
      end
      $finish;
   end

endmodule
